// ===== design/simt_divergence_control_unit_defines.svh =====
// Assertion macros for the SIMT divergence control unit.
// Included by the controller and datapath; needs nothing else.
`ifndef SIMT_DIVERGENCE_CONTROL_UNIT_DEFINES_SVH
`define SIMT_DIVERGENCE_CONTROL_UNIT_DEFINES_SVH

`ifndef SYNTH
`define SDC_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("sdc assertion failed");
`define SDC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("sdc assertion failed");
`else
`define SDC_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons)
`define SDC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

// ===== design/sdc_pkg.sv =====
// Shared types and codes for the SIMT divergence control unit.
// No dependencies.
`timescale 1ns / 1ps

package sdc_pkg;

    localparam logic [2:0] KIND_LAUNCH  = 3'd0;
    localparam logic [2:0] KIND_OP      = 3'd1;
    localparam logic [2:0] KIND_BRANCH  = 3'd2;
    localparam logic [2:0] KIND_RETURN  = 3'd3;
    localparam logic [2:0] KIND_BARRIER = 3'd4;
    localparam logic [2:0] KIND_RELEASE = 3'd5;

    localparam logic [1:0] MODE_READY = 2'd0;
    localparam logic [1:0] MODE_WAIT  = 2'd1;
    localparam logic [1:0] MODE_DONE  = 2'd2;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_PRED_BAR   = 2'd1;
    localparam logic [1:0] ERR_PARKED_BAR = 2'd2;
    localparam logic [1:0] ERR_STACK_FULL = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic        has_predicate;
        logic        predicate_negated;
        logic [31:0] lane_mask;
        logic [15:0] branch_target;
    } evt_item_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [31:0] active_mask;
        logic [31:0] exec_mask;
        logic [1:0]  warp_status;
        logic [1:0]  error_code;
    } res_item_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic pop;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic pop_req;
        logic pop_more;
    } dp_sts_t;

endpackage

// ===== design/sdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sdc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/sdc_ctrl.sv =====
// Controller FSM: item intake, execute, stack pop loop, result hand-off.
// Depends on sdc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "simt_divergence_control_unit_defines.svh"

module sdc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              evt_valid,
    output logic              evt_stall,
    output logic              res_valid,
    input  logic              res_stall,
    input  sdc_pkg::dp_sts_t  sts,
    output sdc_pkg::ctl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       out_free;

    assign out_free  = !res_valid_reg || !res_stall;
    assign evt_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.pop_req)
                begin
                    state_next = S_POP;
                end
                else if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                if (sts.pop_more)
                begin
                    state_next = S_POP;
                end
                else if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    `SDC_ASSERT_IMPLY(a_pop_entry, clk, rst_n, state_reg == S_POP,
        $past(state_reg) == S_EXEC || $past(state_reg) == S_POP)
    `SDC_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, cmd.load_out, !res_valid_reg || !res_stall)
    `SDC_ASSERT_IMPLY(a_exec_after_accept, clk, rst_n, state_reg == S_EXEC,
        $past(evt_valid && !evt_stall))

endmodule

// ===== design/sdc_datapath.sv =====
// Datapath: warp state, event decode, parked-path stack and result register.
// Depends on sdc_pkg, sdc_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "simt_divergence_control_unit_defines.svh"

module sdc_datapath #(
    parameter int LANES       = 32,
    parameter int PC_BITS     = 16,
    parameter int STACK_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sdc_pkg::evt_item_t evt,
    input  sdc_pkg::ctl_cmd_t  cmd,
    output sdc_pkg::dp_sts_t   sts,
    output sdc_pkg::res_item_t res
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = PC_BITS + LANES;

    sdc_pkg::evt_item_t item_reg;
    sdc_pkg::res_item_t res_reg;

    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic [LANES-1:0]   active_reg, active_next;
    logic [LANES-1:0]   exited_reg, exited_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         mode_reg, mode_next;
    logic [LANES-1:0]   exec_reg, exec_next;
    logic [1:0]         err_reg, err_next;

    logic [LANES-1:0]   pmask, pm, m, fall, ret_active, pop_act;
    logic [PC_BITS-1:0] pc_inc, target;
    logic [CW-1:0]      cnt_dec, rd_cnt;
    logic               wr_en, rd_en;
    logic [EW-1:0]      rd_data;

    always_comb
    begin
        pmask      = LANES'(item_reg.lane_mask);
        pm         = item_reg.predicate_negated ? ~pmask : pmask;
        m          = item_reg.has_predicate ? (active_reg & pm) : active_reg;
        fall       = active_reg & ~m;
        ret_active = active_reg & ~m;
        pc_inc     = pc_reg + PC_BITS'(1);
        target     = PC_BITS'(item_reg.branch_target);
        pop_act    = rd_data[LANES-1:0] & ~exited_reg;
        cnt_dec    = count_reg - CW'(1);
        rd_cnt     = cmd.pop ? (cnt_dec - CW'(1)) : cnt_dec;
    end

    always_comb
    begin
        pc_next      = pc_reg;
        active_next  = active_reg;
        exited_next  = exited_reg;
        count_next   = count_reg;
        mode_next    = mode_reg;
        exec_next    = exec_reg;
        err_next     = err_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        sts          = '0;
        if (cmd.exec)
        begin
            exec_next = '0;
            err_next  = sdc_pkg::ERR_NONE;
            if (item_reg.kind == sdc_pkg::KIND_LAUNCH)
            begin
                pc_next     = '0;
                active_next = pmask;
                exited_next = '0;
                count_next  = '0;
                mode_next   = sdc_pkg::MODE_READY;
            end
            else if (item_reg.kind == sdc_pkg::KIND_RELEASE)
            begin
                if (mode_reg == sdc_pkg::MODE_WAIT)
                begin
                    mode_next = sdc_pkg::MODE_READY;
                end
            end
            else if (mode_reg == sdc_pkg::MODE_READY)
            begin
                case (item_reg.kind)
                    sdc_pkg::KIND_OP:
                    begin
                        pc_next   = pc_inc;
                        exec_next = m;
                    end
                    sdc_pkg::KIND_BRANCH:
                    begin
                        exec_next = m;
                        if (m == '0)
                        begin
                            pc_next = pc_inc;
                        end
                        else if (fall == '0)
                        begin
                            pc_next = target;
                        end
                        else if (count_reg >= CW'(STACK_DEPTH))
                        begin
                            exec_next = '0;
                            err_next  = sdc_pkg::ERR_STACK_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + CW'(1);
                            active_next = m;
                            pc_next     = target;
                        end
                    end
                    sdc_pkg::KIND_RETURN:
                    begin
                        exec_next   = m;
                        exited_next = exited_reg | m;
                        active_next = ret_active;
                        pc_next     = pc_inc;
                        if (ret_active == '0)
                        begin
                            if (count_reg != '0)
                            begin
                                sts.pop_req = 1'b1;
                                rd_en       = 1'b1;
                            end
                            else
                            begin
                                mode_next = sdc_pkg::MODE_DONE;
                            end
                        end
                    end
                    sdc_pkg::KIND_BARRIER:
                    begin
                        if (item_reg.has_predicate)
                        begin
                            err_next = sdc_pkg::ERR_PRED_BAR;
                        end
                        else if (count_reg != '0)
                        begin
                            err_next = sdc_pkg::ERR_PARKED_BAR;
                        end
                        else
                        begin
                            pc_next   = pc_inc;
                            mode_next = sdc_pkg::MODE_WAIT;
                            exec_next = active_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (cmd.pop)
        begin
            count_next  = cnt_dec;
            pc_next     = rd_data[EW-1:LANES];
            active_next = pop_act;
            if (pop_act == '0)
            begin
                if (cnt_dec != '0)
                begin
                    sts.pop_more = 1'b1;
                    rd_en        = 1'b1;
                end
                else
                begin
                    mode_next = sdc_pkg::MODE_DONE;
                end
            end
        end
    end

    sdc_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({pc_inc, fall}),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            active_reg <= '0;
            exited_reg <= '0;
            count_reg  <= '0;
            mode_reg   <= sdc_pkg::MODE_READY;
        end
        else
        begin
            pc_reg     <= pc_next;
            active_reg <= active_next;
            exited_reg <= exited_next;
            count_reg  <= count_next;
            mode_reg   <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exec_reg <= exec_next;
        err_reg  <= err_next;
        if (cmd.capture)
        begin
            item_reg <= evt;
        end
        if (cmd.load_out)
        begin
            res_reg.next_pc     <= 16'(pc_next);
            res_reg.active_mask <= 32'(active_next);
            res_reg.exec_mask   <= 32'(exec_next);
            res_reg.warp_status <= mode_next;
            res_reg.error_code  <= err_next;
        end
    end

    assign res = res_reg;

    `SDC_ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, cmd.pop, count_reg != '0)
    `SDC_ASSERT_NEXT(a_push_bounded, clk, rst_n, wr_en,
        count_reg != '0 && count_reg <= CW'(STACK_DEPTH))

endmodule

// ===== design/simt_divergence_control_unit.sv =====
// Top level of the SIMT divergence control unit: one warp's pc, lane masks,
// parked-path stack and status. Depends on sdc_pkg, sdc_ctrl, sdc_datapath.
//
//   channel | signals                 | payload
//   --------+-------------------------+-------------------------------
//   event   | evt_valid, evt_stall    | evt (sdc_pkg::evt_item_t)
//   result  | res_valid, res_stall    | res (sdc_pkg::res_item_t)
//
// An item is captured while idle, then executed; unless it pops or the output
// is stalled, the result is loaded in that same cycle. A return that empties
// the active lanes pops parked paths, one pop per cycle, till one is live or none is left.
// Asynchronous active-low reset; no clearing pass, stack entries are written
// before read. A stalled result holds in the output register; the next item
// is taken meanwhile and waits before load if the result is still stalled.
`timescale 1ns / 1ps

module simt_divergence_control_unit #(
    parameter int LANES       = 32,
    parameter int PC_BITS     = 16,
    parameter int STACK_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               evt_valid,
    output logic               evt_stall,
    input  sdc_pkg::evt_item_t evt,
    output logic               res_valid,
    input  logic               res_stall,
    output sdc_pkg::res_item_t res
);

    sdc_pkg::ctl_cmd_t cmd;
    sdc_pkg::dp_sts_t  sts;

    sdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sdc_datapath #(
        .LANES       (LANES),
        .PC_BITS     (PC_BITS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .cmd   (cmd),
        .sts   (sts),
        .res   (res)
    );

endmodule
